// ===== rtl/core/gjdc_pkg.sv =====
// Shared types, constants and lookup functions for the Julian day number converter.
package gjdc_pkg;

  // Payload of one input beat.
  typedef struct packed {
    logic        func;
    logic [4:0]  day;
    logic [3:0]  month;
    logic [13:0] year;
    logic [22:0] day_number;
  } in_t;

  // Payload of one result beat.
  typedef struct packed {
    logic [22:0] result_day_number;
    logic [4:0]  result_day;
    logic [3:0]  result_month;
    logic [13:0] result_year;
    logic        valid_res;
  } out_t;

  // Operation selector codes.
  localparam logic FuncToJdn  = 1'b0;
  localparam logic FuncToDate = 1'b1;

  // Register stages inside each conversion datapath.
  localparam int unsigned PipeDepth = 6;

  // Supported range: 1 Jan 0000 to 31 Dec 9999.
  localparam logic [22:0] JdnMin  = 23'd1721060;
  localparam logic [22:0] JdnMax  = 23'd5373484;
  localparam logic [13:0] YearMax = 14'd9999;

  localparam logic [23:0] JdnBias     = 24'd32044;
  localparam logic [23:0] DateBias    = 24'd32045;
  localparam logic [14:0] EpochYears  = 15'd4800;
  localparam logic [25:0] DaysPer400  = 26'd146097;
  localparam logic [18:0] DaysPer4    = 19'd1461;
  localparam logic [22:0] DaysPerYear = 23'd365;
  localparam logic [14:0] Century     = 15'd100;

  // Month index counted from March has January and February as ten and eleven; MonFeb and MonDec are calendar months.
  localparam logic [3:0] MonJan = 4'd10;
  localparam logic [3:0] MonFeb = 4'd2;
  localparam logic [3:0] MonDec = 4'd12;

  // Reciprocals for exact division by a constant: q = (x * Recip) >> Shift,
  // with Shift = width of x plus bits of the divisor.
  localparam int unsigned QuadShift = 44;
  localparam logic [26:0] RecipQuad =
    27'(((64'd1 << QuadShift) + 64'd146097 - 64'd1) / 64'd146097);

  localparam int unsigned Year4Shift = 29;
  localparam logic [18:0] RecipYear4 =
    19'(((64'd1 << Year4Shift) + 64'd1461 - 64'd1) / 64'd1461);

  localparam int unsigned MonShift = 20;
  localparam logic [12:0] RecipMon =
    13'(((64'd1 << MonShift) + 64'd153 - 64'd1) / 64'd153);

  localparam int unsigned CentYShift = 21;
  localparam logic [14:0] RecipCentY =
    15'(((64'd1 << CentYShift) + 64'd100 - 64'd1) / 64'd100);

  localparam int unsigned CentYyShift = 22;
  localparam logic [15:0] RecipCentYy =
    16'(((64'd1 << CentYyShift) + 64'd100 - 64'd1) / 64'd100);

  // Days before the first of a month, months counted from March.
  function automatic logic [8:0] month_offset(input logic [3:0] mm);
    logic [8:0] v;
    unique case (mm)
      4'd0:    v = 9'd0;
      4'd1:    v = 9'd31;
      4'd2:    v = 9'd61;
      4'd3:    v = 9'd92;
      4'd4:    v = 9'd122;
      4'd5:    v = 9'd153;
      4'd6:    v = 9'd184;
      4'd7:    v = 9'd214;
      4'd8:    v = 9'd245;
      4'd9:    v = 9'd275;
      4'd10:   v = 9'd306;
      4'd11:   v = 9'd337;
      default: v = 9'd0;
    endcase
    return v;
  endfunction

  // Length of a calendar month, January is one.
  function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
    logic [4:0] v;
    unique case (m)
      4'd4, 4'd6, 4'd9, 4'd11: v = 5'd30;
      MonFeb:                  v = leap ? 5'd29 : 5'd28;
      default:                 v = 5'd31;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/core/gjdc_date2jdn.sv =====
// Pipelined date to Julian day number datapath with date check.
module gjdc_date2jdn
  import gjdc_pkg::*;
(
  input  logic clk,
  input  in_t  in_data,
  output out_t res
);

  // stage 1
  logic [13:0] s1_year_r, s1_year_nxt;
  logic [4:0]  s1_day_r, s1_day_nxt;
  logic [3:0]  s1_mon_r, s1_mon_nxt;
  logic [7:0]  s1_q_r, s1_q_nxt;
  logic [14:0] s1_yy_r, s1_yy_nxt;
  logic [3:0]  s1_mm_r, s1_mm_nxt;
  // stage 2
  logic        s2_ok_r, s2_ok_nxt;
  logic [4:0]  s2_day_r, s2_day_nxt;
  logic [3:0]  s2_mm_r, s2_mm_nxt;
  logic [14:0] s2_yy_r, s2_yy_nxt;
  logic [8:0]  s2_yyq_r, s2_yyq_nxt;
  // stage 3
  logic [22:0] s3_sum_r, s3_sum_nxt;
  logic        s3_ok_r, s3_ok_nxt;
  logic [4:0]  s3_day_r, s3_day_nxt;
  logic [3:0]  s3_mm_r, s3_mm_nxt;
  // stages 4 to 6
  logic [22:0] s4_dn_r, s4_dn_nxt;
  logic        s4_ok_r, s4_ok_nxt;
  logic [22:0] s5_dn_r, s6_dn_r;
  logic        s5_ok_r, s6_ok_r;

  logic        early;
  logic [28:0] prod_y;
  logic [30:0] prod_yy;
  logic [13:0] rem100;
  logic        leap;
  logic [23:0] dn;

  // Stage 1: split the year at March, take year / 100.
  always_comb begin
    early      = (in_data.month <= MonFeb);
    s1_year_nxt = in_data.year;
    s1_day_nxt  = in_data.day;
    s1_mon_nxt  = in_data.month;
    s1_yy_nxt   = 15'(in_data.year) + EpochYears - 15'(early);
    s1_mm_nxt   = early ? in_data.month + 4'd9 : in_data.month - 4'd3;
    prod_y      = 29'(in_data.year) * 29'(RecipCentY);
    s1_q_nxt    = prod_y[CentYShift+7:CentYShift];
  end

  // Stage 2: leap rule and range check; shifted year / 100.
  always_comb begin
    rem100     = s1_year_r - 14'(15'(s1_q_r) * Century);
    leap       = (s1_year_r[1:0] == 2'b00) && ((rem100 != 14'd0) || (s1_q_r[1:0] == 2'b00));
    s2_ok_nxt  = (s1_year_r <= YearMax) && (s1_mon_r != 4'd0) && (s1_mon_r <= MonDec) &&
                 (s1_day_r != 5'd0) && (s1_day_r <= month_len(s1_mon_r, leap));
    s2_day_nxt = s1_day_r;
    s2_mm_nxt  = s1_mm_r;
    s2_yy_nxt  = s1_yy_r;
    prod_yy    = 31'(s1_yy_r) * 31'(RecipCentYy);
    s2_yyq_nxt = prod_yy[CentYyShift+8:CentYyShift];
  end

  // Stage 3: days in whole years since the epoch.
  always_comb begin
    s3_sum_nxt = 23'(s2_yy_r) * DaysPerYear + 23'(s2_yy_r >> 2) - 23'(s2_yyq_r)
                 + 23'(s2_yyq_r >> 2);
    s3_ok_nxt  = s2_ok_r;
    s3_day_nxt = s2_day_r;
    s3_mm_nxt  = s2_mm_r;
  end

  // Stage 4: add the month and day, drop the number for a bad date.
  always_comb begin
    dn        = 24'(s3_sum_r) + 24'(s3_day_r) + 24'(month_offset(s3_mm_r)) - DateBias;
    s4_dn_nxt = s3_ok_r ? dn[22:0] : 23'd0;
    s4_ok_nxt = s3_ok_r;
  end

  always_ff @(posedge clk) begin
    s1_year_r <= s1_year_nxt;
    s1_day_r  <= s1_day_nxt;
    s1_mon_r  <= s1_mon_nxt;
    s1_q_r    <= s1_q_nxt;
    s1_yy_r   <= s1_yy_nxt;
    s1_mm_r   <= s1_mm_nxt;
    s2_ok_r   <= s2_ok_nxt;
    s2_day_r  <= s2_day_nxt;
    s2_mm_r   <= s2_mm_nxt;
    s2_yy_r   <= s2_yy_nxt;
    s2_yyq_r  <= s2_yyq_nxt;
    s3_sum_r  <= s3_sum_nxt;
    s3_ok_r   <= s3_ok_nxt;
    s3_day_r  <= s3_day_nxt;
    s3_mm_r   <= s3_mm_nxt;
    s4_dn_r   <= s4_dn_nxt;
    s4_ok_r   <= s4_ok_nxt;
    // hold alignment with the other datapath
    s5_dn_r   <= s4_dn_r;
    s5_ok_r   <= s4_ok_r;
    s6_dn_r   <= s5_dn_r;
    s6_ok_r   <= s5_ok_r;
  end

  always_comb begin
    res                   = '0;
    res.result_day_number = s6_dn_r;
    res.valid_res         = s6_ok_r;
  end

endmodule

// ===== rtl/core/gjdc_jdn2date.sv =====
// Pipelined Julian day number to date datapath with range check.
module gjdc_jdn2date
  import gjdc_pkg::*;
(
  input  logic clk,
  input  in_t  in_data,
  output out_t res
);

  logic [23:0] s1_a_r, s1_a_nxt;
  logic [7:0]  s1_b_r, s1_b_nxt;
  logic        s1_ok_r, s1_ok_nxt;

  logic [15:0] s2_c_r, s2_c_nxt;
  logic [7:0]  s2_b_r;
  logic        s2_ok_r;

  logic [15:0] s3_c_r;
  logic [7:0]  s3_dd_r, s3_dd_nxt;
  logic [7:0]  s3_b_r;
  logic        s3_ok_r;

  logic [8:0]  s4_e_r, s4_e_nxt;
  logic [7:0]  s4_dd_r, s4_b_r;
  logic        s4_ok_r;

  logic [8:0]  s5_e_r;
  logic [3:0]  s5_mm_r, s5_mm_nxt;
  logic [7:0]  s5_dd_r, s5_b_r;
  logic        s5_ok_r;

  out_t        res_r, res_nxt;

  logic [52:0] prod_b;
  logic [25:0] prod_c;
  logic [23:0] c_full;
  logic [36:0] prod_dd;
  logic [18:0] prod_e;
  logic [16:0] e_full;
  logic [11:0] x_mm;
  logic [24:0] prod_mm;
  logic        jan;
  logic [8:0]  d_full;
  logic [14:0] y_full;

  // Stage 1: century count.
  always_comb begin
    s1_a_nxt  = 24'(in_data.day_number) + JdnBias;
    prod_b    = 53'({s1_a_nxt, 2'b11}) * 53'(RecipQuad);
    s1_b_nxt  = prod_b[QuadShift+7:QuadShift];
    s1_ok_nxt = (in_data.day_number >= JdnMin) && (in_data.day_number <= JdnMax);
  end

  // Stage 2: day within the century.
  always_comb begin
    prod_c   = 26'(s1_b_r) * DaysPer400;
    c_full   = s1_a_r - 24'(prod_c >> 2);
    s2_c_nxt = c_full[15:0];
  end

  // Stage 3: year within the century.
  always_comb begin
    prod_dd   = 37'({s2_c_r, 2'b11}) * 37'(RecipYear4);
    s3_dd_nxt = prod_dd[Year4Shift+7:Year4Shift];
  end

  // Stage 4: day within the year, counted from March.
  always_comb begin
    prod_e   = 19'(s3_dd_r) * DaysPer4;
    e_full   = 17'(s3_c_r) - 17'(prod_e >> 2);
    s4_e_nxt = e_full[8:0];
  end

  // Stage 5: month counted from March.
  always_comb begin
    x_mm      = 12'(s4_e_r) * 12'd5 + 12'd2;
    prod_mm   = 25'(x_mm) * 25'(RecipMon);
    s5_mm_nxt = prod_mm[MonShift+3:MonShift];
  end

  // Stage 6: calendar day, month and year; zero them out of range.
  always_comb begin
    jan     = (s5_mm_r >= MonJan);
    d_full  = s5_e_r - month_offset(s5_mm_r) + 9'd1;
    y_full  = 15'(s5_b_r) * Century + 15'(s5_dd_r) + 15'(jan) - EpochYears;
    res_nxt = '0;
    if (s5_ok_r) begin
      res_nxt.result_day   = d_full[4:0];
      res_nxt.result_month = jan ? s5_mm_r - 4'd9 : s5_mm_r + 4'd3;
      res_nxt.result_year  = y_full[13:0];
      res_nxt.valid_res    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    s1_a_r  <= s1_a_nxt;
    s1_b_r  <= s1_b_nxt;
    s1_ok_r <= s1_ok_nxt;
    s2_c_r  <= s2_c_nxt;
    s2_b_r  <= s1_b_r;
    s2_ok_r <= s1_ok_r;
    s3_c_r  <= s2_c_r;
    s3_dd_r <= s3_dd_nxt;
    s3_b_r  <= s2_b_r;
    s3_ok_r <= s2_ok_r;
    s4_e_r  <= s4_e_nxt;
    s4_dd_r <= s3_dd_r;
    s4_b_r  <= s3_b_r;
    s4_ok_r <= s3_ok_r;
    s5_e_r  <= s4_e_r;
    s5_mm_r <= s5_mm_nxt;
    s5_dd_r <= s4_dd_r;
    s5_b_r  <= s4_b_r;
    s5_ok_r <= s4_ok_r;
    res_r   <= res_nxt;
  end

  assign res = res_r;

endmodule

// ===== rtl/core/gregorian_julian_day_converter_core.sv =====
// Top level of the Gregorian date / Julian day number converter.
//
//   channel | ports                   | handshake
//   --------+-------------------------+-------------------------------------
//   input   | start, busy, in_data    | beat taken when start && !busy
//   result  | out_strobe, out_data    | beat shown for one cycle on strobe
//
// One beat is taken every cycle; busy stays low, nothing ever holds the input.
// Each result appears on out_strobe once it has passed the input register, six
// stages of the conversion datapaths (set by the chain of reciprocal multiplies
// for day number to date) and the result register.
// Reset clears only the valid chain and the strobe; beats in flight are dropped, not reissued.
// The receiver cannot stall, so results are simply shown once and dropped.
module gregorian_julian_day_converter_core
  import gjdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic start,
  output logic busy,
  input  in_t  in_data,
  output logic out_strobe,
  output out_t out_data
);

  logic                 accept;
  in_t                  in_r, in_nxt;
  logic [PipeDepth:0]   vld_r, vld_nxt;
  logic [PipeDepth:0]   func_r, func_nxt;
  out_t                 out_r, out_nxt;
  logic                 out_strobe_r, out_strobe_nxt;
  out_t                 jdn_res;
  out_t                 date_res;

  // Nothing in the datapath stalls, so never push back.
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // Capture the beat; both datapaths work on it, the selector picks one later.
  always_comb begin
    in_nxt = accept ? in_data : in_r;
  end

  // Advance valid and selector alongside the payload, stage 0 is the input register.
  always_comb begin
    vld_nxt  = {vld_r[PipeDepth-1:0], accept};
    func_nxt = {func_r[PipeDepth-1:0], in_data.func};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r   <= in_nxt;
    func_r <= func_nxt;
  end

  gjdc_date2jdn u_date2jdn (
    .clk     (clk),
    .in_data (in_r),
    .res     (jdn_res)
  );

  gjdc_jdn2date u_jdn2date (
    .clk     (clk),
    .in_data (in_r),
    .res     (date_res)
  );

  // Select the result of the requested operation; the other one's fields stay zero.
  always_comb begin
    out_strobe_nxt = vld_r[PipeDepth];
    unique case (func_r[PipeDepth])
      FuncToDate: out_nxt = date_res;
      default:    out_nxt = jdn_res;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= out_strobe_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_strobe = out_strobe_r;
  assign out_data   = out_r;

`ifndef SYNTHESIS
  // Every accepted beat comes out after the fixed latency.
  a_latency : assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##8 out_strobe)
    else $error("accepted beat did not reach the result port");

  // An invalid result carries all-zero fields.
  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && !out_data.valid_res |->
      out_data.result_day_number == 23'd0 && out_data.result_day == 5'd0 &&
      out_data.result_month == 4'd0 && out_data.result_year == 14'd0)
    else $error("invalid result with non-zero fields");

  // A valid day number lies in the supported range.
  a_jdn_range : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.valid_res && out_data.result_day_number != 23'd0 |->
      out_data.result_day_number >= JdnMin && out_data.result_day_number <= JdnMax)
    else $error("day number out of range");

  // A valid decoded date has a real month and day.
  a_date_fields : assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe && out_data.valid_res && out_data.result_day_number == 23'd0 |->
      out_data.result_month != 4'd0 && out_data.result_month <= MonDec &&
      out_data.result_day != 5'd0 && out_data.result_year <= YearMax)
    else $error("decoded date fields out of range");
`endif

endmodule
